[rtl/pps_pkg.sv]
// Shared types and constants of the preemptive priority scheduler.
package pps_pkg;

  localparam int SLOTS_DEF  = 16;

  localparam int CMD_W      = 1;
  localparam int SLOT_W     = 4;
  localparam int TIME_W     = 16;
  localparam int PRIO_W     = 8;
  localparam int COUNT_W    = 5;
  localparam int SUM_W      = 20;
  localparam int ACTIVE_W   = 5;

  localparam logic [CMD_W-1:0]   CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0]   CMD_TICK  = 1'b1;

  localparam logic [TIME_W-1:0]  TICK_MAX  = 16'hFFFF;
  localparam logic [SUM_W-1:0]   SUM_MAX   = 20'hFFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // One task slot as held in the slot memory
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
    logic [PRIO_W-1:0] prio;
  } slot_ent_t;

endpackage

[rtl/pps_in_if.sv]
// Input channel of the scheduler: load and tick commands.
interface pps_in_if;
  logic                         valid;
  logic                         ready;
  logic [pps_pkg::CMD_W-1:0]    cmd;
  logic [pps_pkg::SLOT_W-1:0]   slot;
  logic [pps_pkg::TIME_W-1:0]   arrival;
  logic [pps_pkg::TIME_W-1:0]   burst;
  logic [pps_pkg::PRIO_W-1:0]   prio;

  modport source (output valid, cmd, slot, arrival, burst, prio, input ready);
  modport sink   (input valid, cmd, slot, arrival, burst, prio, output ready);
endinterface

[rtl/pps_out_if.sv]
// Result channel of the scheduler: one beat per command.
interface pps_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ran;
  logic [pps_pkg::SLOT_W-1:0]    served_slot;
  logic                          finished;
  logic [pps_pkg::TIME_W-1:0]    wait_ticks;
  logic [pps_pkg::TIME_W-1:0]    turnaround_ticks;
  logic [pps_pkg::COUNT_W-1:0]   done_count;
  logic                          all_done;
  logic [pps_pkg::SUM_W-1:0]     wait_total;
  logic [pps_pkg::SUM_W-1:0]     turnaround_total;

  modport source (output valid, ran, served_slot, finished, wait_ticks, turnaround_ticks,
                  done_count, all_done, wait_total, turnaround_total, input ready);
  modport sink   (input valid, ran, served_slot, finished, wait_ticks, turnaround_ticks,
                  done_count, all_done, wait_total, turnaround_total, output ready);
endinterface

[rtl/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler: slot memory, scan sequencer and result register.
// Load beat: the accept moves to the response step, which registers the result.
// Tick beat: the scan, execute and sum steps run before the response step; the
//   single read port of the slot memory scans one slot per cycle.
// One command is in flight at a time; a new one is taken while a result waits.
// Synchronous active-low reset clears time, counts, sums, slot valid bits and
//   active_slots; slot memory contents stay undefined until loaded.
module preemptive_priority_scheduler #(
  parameter int SLOTS = pps_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pps_in_if.sink                         in_ch,
  pps_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [pps_pkg::ACTIVE_W-1:0]   cfg_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int AW = $clog2(SLOTS + 1);
  localparam int WW = (AW > pps_pkg::ACTIVE_W) ? AW : pps_pkg::ACTIVE_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_RESP = 3'd4;

  localparam int TW = pps_pkg::TIME_W;

  logic [2:0]                      state_r;
  logic [pps_pkg::ACTIVE_W-1:0]    active_r;
  logic [TW-1:0]                   now_tick_r;
  logic [pps_pkg::COUNT_W-1:0]     completed_r;
  logic [pps_pkg::SUM_W-1:0]       wait_sum_r;
  logic [pps_pkg::SUM_W-1:0]       tat_sum_r;
  logic [SLOTS-1:0]                valid_r;

  // slot memory and its registered read port
  pps_pkg::slot_ent_t              mem [SLOTS];
  pps_pkg::slot_ent_t              rd_ent_r;
  logic                            mem_we;
  logic [IW-1:0]                   mem_waddr;
  pps_pkg::slot_ent_t              mem_wdata;
  logic [IW-1:0]                   mem_raddr;

  // scan sequencer
  logic [IW:0]                     scan_idx_r;
  logic [IW-1:0]                   rd_idx_r;
  logic                            rd_vld_r;
  logic                            found_r;
  logic [IW-1:0]                   best_idx_r;
  pps_pkg::slot_ent_t              best_ent_r;

  // per-command result
  logic                            res_ran_r;
  logic [pps_pkg::SLOT_W-1:0]      res_slot_r;
  logic                            res_fin_r;
  logic [TW-1:0]                   res_wt_r;
  logic [TW-1:0]                   res_tat_r;

  // output register
  logic                            out_valid_r;
  logic                            out_ran_r;
  logic [pps_pkg::SLOT_W-1:0]      out_slot_r;
  logic                            out_fin_r;
  logic [TW-1:0]                   out_wt_r;
  logic [TW-1:0]                   out_tat_r;
  logic [pps_pkg::COUNT_W-1:0]     out_done_r;
  logic                            out_all_r;
  logic [pps_pkg::SUM_W-1:0]       out_wsum_r;
  logic [pps_pkg::SUM_W-1:0]       out_tsum_r;

  logic                            in_acc;
  logic                            out_free;
  logic [WW-1:0]                   eff_active;
  logic                            load_ok;
  logic                            rd_ready;
  logic                            rd_better;
  logic [TW:0]                     full_nxt;
  logic [TW:0]                     wdiff_nxt;
  logic [TW-1:0]                   tat_nxt;
  logic [TW-1:0]                   wt_nxt;
  logic                            fin_nxt;
  logic [pps_pkg::SUM_W:0]         wsum_add;
  logic [pps_pkg::SUM_W:0]         tsum_add;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // clamp active_slots to the table size
  assign eff_active = (WW'(active_r) > WW'(SLOTS)) ? WW'(SLOTS) : WW'(active_r);
  assign load_ok    = (32'(in_ch.slot) < SLOTS);

  // judge the slot read back in this cycle
  assign rd_ready  = rd_vld_r && valid_r[rd_idx_r] && (WW'(rd_idx_r) < eff_active) &&
                     (rd_ent_r.arrival <= now_tick_r) && (rd_ent_r.remaining != '0);
  assign rd_better = !found_r || (rd_ent_r.prio < best_ent_r.prio);

  // completion times of the chosen slot
  assign fin_nxt   = found_r && (best_ent_r.remaining == TW'(1));
  assign full_nxt  = {1'b0, now_tick_r} + (TW+1)'(1) - {1'b0, best_ent_r.arrival};
  assign wdiff_nxt = (full_nxt > {1'b0, best_ent_r.burst}) ?
                     (full_nxt - {1'b0, best_ent_r.burst}) : '0;
  assign tat_nxt   = full_nxt[TW] ? pps_pkg::TICK_MAX : full_nxt[TW-1:0];
  assign wt_nxt    = wdiff_nxt[TW] ? pps_pkg::TICK_MAX : wdiff_nxt[TW-1:0];

  assign wsum_add  = {1'b0, wait_sum_r} + (pps_pkg::SUM_W+1)'(res_wt_r);
  assign tsum_add  = {1'b0, tat_sum_r}  + (pps_pkg::SUM_W+1)'(res_tat_r);

  // memory write: load beat in idle, remaining-time write-back after the scan
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = IW'(in_ch.slot);
    mem_wdata.arrival   = in_ch.arrival;
    mem_wdata.burst     = in_ch.burst;
    mem_wdata.remaining = in_ch.burst;
    mem_wdata.prio      = in_ch.prio;
    if (state_r == ST_IDLE) begin
      mem_we = in_acc && (in_ch.cmd == pps_pkg::CMD_LOAD) && load_ok;
    end else if (state_r == ST_EXEC) begin
      mem_we    = found_r;
      mem_waddr = best_idx_r;
      mem_wdata = best_ent_r;
      mem_wdata.remaining = best_ent_r.remaining - TW'(1);
    end
  end

  assign mem_raddr = scan_idx_r[IW-1:0];

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_ent_r <= mem[mem_raddr];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cfg_we) begin
      active_r <= cfg_data;
    end
  end

  // sequencer and running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_tick_r  <= '0;
      completed_r <= '0;
      wait_sum_r  <= '0;
      tat_sum_r   <= '0;
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      scan_idx_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_ch.cmd == pps_pkg::CMD_LOAD) begin
              if (load_ok) begin
                valid_r[IW'(in_ch.slot)] <= 1'b1;
              end
              res_ran_r  <= 1'b0;
              res_slot_r <= '0;
              res_fin_r  <= 1'b0;
              res_wt_r   <= '0;
              res_tat_r  <= '0;
              state_r    <= ST_RESP;
            end else begin
              scan_idx_r <= '0;
              rd_vld_r   <= 1'b0;
              found_r    <= 1'b0;
              state_r    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // issue one read per cycle, judge the previous one
          rd_idx_r <= scan_idx_r[IW-1:0];
          rd_vld_r <= (scan_idx_r < (IW+1)'(SLOTS));
          if (rd_ready && rd_better) begin
            found_r    <= 1'b1;
            best_idx_r <= rd_idx_r;
            best_ent_r <= rd_ent_r;
          end
          if (scan_idx_r == (IW+1)'(SLOTS)) begin
            state_r <= ST_EXEC;
          end else begin
            scan_idx_r <= scan_idx_r + (IW+1)'(1);
          end
        end
        ST_EXEC: begin
          rd_vld_r   <= 1'b0;
          res_ran_r  <= found_r;
          res_slot_r <= found_r ? pps_pkg::SLOT_W'(best_idx_r) : '0;
          res_fin_r  <= fin_nxt;
          res_wt_r   <= fin_nxt ? wt_nxt : '0;
          res_tat_r  <= fin_nxt ? tat_nxt : '0;
          state_r    <= ST_SUM;
        end
        ST_SUM: begin
          // fold a completion into the totals, advance time
          if (res_fin_r) begin
            if (completed_r != pps_pkg::COUNT_MAX) begin
              completed_r <= completed_r + pps_pkg::COUNT_W'(1);
            end
            wait_sum_r <= (wsum_add > {1'b0, pps_pkg::SUM_MAX}) ?
                          pps_pkg::SUM_MAX : wsum_add[pps_pkg::SUM_W-1:0];
            tat_sum_r  <= (tsum_add > {1'b0, pps_pkg::SUM_MAX}) ?
                          pps_pkg::SUM_MAX : tsum_add[pps_pkg::SUM_W-1:0];
          end
          if (now_tick_r != pps_pkg::TICK_MAX) begin
            now_tick_r <= now_tick_r + TW'(1);
          end
          state_r <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RESP && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESP && out_free) begin
      out_ran_r  <= res_ran_r;
      out_slot_r <= res_slot_r;
      out_fin_r  <= res_fin_r;
      out_wt_r   <= res_wt_r;
      out_tat_r  <= res_tat_r;
      out_done_r <= completed_r;
      out_all_r  <= (WW'(completed_r) == eff_active);
      out_wsum_r <= wait_sum_r;
      out_tsum_r <= tat_sum_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.ran              = out_ran_r;
  assign out_ch.served_slot      = out_slot_r;
  assign out_ch.finished         = out_fin_r;
  assign out_ch.wait_ticks       = out_wt_r;
  assign out_ch.turnaround_ticks = out_tat_r;
  assign out_ch.done_count       = out_done_r;
  assign out_ch.all_done         = out_all_r;
  assign out_ch.wait_total       = out_wsum_r;
  assign out_ch.turnaround_total = out_tsum_r;

  // a result beat only appears after the response step
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RESP)
    else $error("result beat raised outside the response step");

  // a completion is always a served tick
  a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_fin_r || out_ran_r))
    else $error("finished without a served slot");

  // the completion count never falls outside reset
  a_done_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> completed_r >= $past(completed_r))
    else $error("completion count decreased");

  // the scan counter never runs past the table
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> scan_idx_r <= (IW+1)'(SLOTS))
    else $error("scan index beyond slot table");

endmodule
